>>> design/sfsc_pkg.sv
package sfsc_pkg;

    // field widths
    localparam int TEMP_W  = 8;
    localparam int STATE_W = 3;
    localparam int PIN_W   = 3;
    localparam int WAIT_W  = 16;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 3;

    // fan states
    localparam logic [STATE_W-1:0] MODE_STOPPED  = 3'd0;
    localparam logic [STATE_W-1:0] MODE_STOPPING = 3'd1;
    localparam logic [STATE_W-1:0] MODE_SPEED1   = 3'd2;
    localparam logic [STATE_W-1:0] MODE_SPEED2   = 3'd3;
    localparam logic [STATE_W-1:0] MODE_SPEED3   = 3'd4;
    localparam logic [STATE_W-1:0] MODE_SPEED4   = 3'd5;
    localparam logic [STATE_W-1:0] MODE_SPEED5   = 3'd6;

    // request kinds carried on the input user bit
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD_ONE   = 3'd0;
    localparam logic [IDX_W-1:0] REG_THRESHOLD_TWO   = 3'd1;
    localparam logic [IDX_W-1:0] REG_THRESHOLD_THREE = 3'd2;
    localparam logic [IDX_W-1:0] REG_THRESHOLD_FOUR  = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD_FIVE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_RUN_DOWN        = 3'd5;

    // register reset values
    localparam logic [TEMP_W-1:0] RST_THRESHOLD_ONE   = 8'd55;
    localparam logic [TEMP_W-1:0] RST_THRESHOLD_TWO   = 8'd60;
    localparam logic [TEMP_W-1:0] RST_THRESHOLD_THREE = 8'd65;
    localparam logic [TEMP_W-1:0] RST_THRESHOLD_FOUR  = 8'd70;
    localparam logic [TEMP_W-1:0] RST_THRESHOLD_FIVE  = 8'd75;
    localparam logic [WAIT_W-1:0] RST_RUN_DOWN        = 16'd120;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    typedef struct packed {
        logic [TEMP_W-1:0] threshold_one;
        logic [TEMP_W-1:0] threshold_two;
        logic [TEMP_W-1:0] threshold_three;
        logic [TEMP_W-1:0] threshold_four;
        logic [TEMP_W-1:0] threshold_five;
        logic [WAIT_W-1:0] run_down_seconds;
    } sfsc_cfg_t;

    // pin drive pattern for each fan state
    function automatic logic [PIN_W-1:0] pin_of(input logic [STATE_W-1:0] mode);
        logic [PIN_W-1:0] pins;
        case (mode)
            MODE_STOPPED:  pins = 3'd0;
            MODE_STOPPING: pins = 3'd1;
            MODE_SPEED1:   pins = 3'd1;
            MODE_SPEED2:   pins = 3'd2;
            MODE_SPEED3:   pins = 3'd5;
            MODE_SPEED4:   pins = 3'd3;
            MODE_SPEED5:   pins = 3'd7;
            default:       pins = 3'd0;
        endcase
        return pins;
    endfunction

endpackage

>>> design/sfsc_regs.sv
module sfsc_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfsc_pkg::ADDR_W-1:0] paddr,
    input  logic [sfsc_pkg::DATA_W-1:0] pwdata,
    output logic [sfsc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    output sfsc_pkg::sfsc_cfg_t          cfg
);

    sfsc_pkg::sfsc_cfg_t cfg_reg;
    sfsc_pkg::sfsc_cfg_t cfg_next;
    logic [sfsc_pkg::IDX_W-1:0] idx;
    logic wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[sfsc_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                sfsc_pkg::REG_THRESHOLD_ONE:
                    cfg_next.threshold_one = pwdata[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_TWO:
                    cfg_next.threshold_two = pwdata[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_THREE:
                    cfg_next.threshold_three = pwdata[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_FOUR:
                    cfg_next.threshold_four = pwdata[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_FIVE:
                    cfg_next.threshold_five = pwdata[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_RUN_DOWN:
                    cfg_next.run_down_seconds = pwdata[sfsc_pkg::WAIT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_one    <= sfsc_pkg::RST_THRESHOLD_ONE;
            cfg_reg.threshold_two    <= sfsc_pkg::RST_THRESHOLD_TWO;
            cfg_reg.threshold_three  <= sfsc_pkg::RST_THRESHOLD_THREE;
            cfg_reg.threshold_four   <= sfsc_pkg::RST_THRESHOLD_FOUR;
            cfg_reg.threshold_five   <= sfsc_pkg::RST_THRESHOLD_FIVE;
            cfg_reg.run_down_seconds <= sfsc_pkg::RST_RUN_DOWN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // register read mux
    always_comb
    begin
        unique case (idx)
            sfsc_pkg::REG_THRESHOLD_ONE:
                prdata = {{(sfsc_pkg::DATA_W-sfsc_pkg::TEMP_W){1'b0}}, cfg_reg.threshold_one};
            sfsc_pkg::REG_THRESHOLD_TWO:
                prdata = {{(sfsc_pkg::DATA_W-sfsc_pkg::TEMP_W){1'b0}}, cfg_reg.threshold_two};
            sfsc_pkg::REG_THRESHOLD_THREE:
                prdata = {{(sfsc_pkg::DATA_W-sfsc_pkg::TEMP_W){1'b0}}, cfg_reg.threshold_three};
            sfsc_pkg::REG_THRESHOLD_FOUR:
                prdata = {{(sfsc_pkg::DATA_W-sfsc_pkg::TEMP_W){1'b0}}, cfg_reg.threshold_four};
            sfsc_pkg::REG_THRESHOLD_FIVE:
                prdata = {{(sfsc_pkg::DATA_W-sfsc_pkg::TEMP_W){1'b0}}, cfg_reg.threshold_five};
            sfsc_pkg::REG_RUN_DOWN:
                prdata = {{(sfsc_pkg::DATA_W-sfsc_pkg::WAIT_W){1'b0}},
                          cfg_reg.run_down_seconds};
            default:
                prdata = '0;
        endcase
    end

endmodule

>>> design/sfsc_step.sv
module sfsc_step (
    input  logic                          opcode,
    input  logic [sfsc_pkg::TEMP_W-1:0]  temperature,
    input  logic [sfsc_pkg::STATE_W-1:0] mode,
    input  logic [sfsc_pkg::WAIT_W-1:0]  wait_count,
    input  sfsc_pkg::sfsc_cfg_t           cfg,
    output logic [sfsc_pkg::STATE_W-1:0] mode_next,
    output logic [sfsc_pkg::WAIT_W-1:0]  wait_next,
    output logic [sfsc_pkg::PIN_W-1:0]   pins
);

    logic ge1, ge2, ge3, ge4, ge5;

    // threshold compares
    assign ge1 = temperature >= cfg.threshold_one;
    assign ge2 = temperature >= cfg.threshold_two;
    assign ge3 = temperature >= cfg.threshold_three;
    assign ge4 = temperature >= cfg.threshold_four;
    assign ge5 = temperature >= cfg.threshold_five;

    // ordered range tests; ticks and an unfinished run-down keep the state
    always_comb
    begin
        mode_next = mode;
        wait_next = wait_count;
        if (opcode == sfsc_pkg::OP_TICK)
        begin
            if (wait_count != sfsc_pkg::WAIT_MAX)
                wait_next = wait_count + 1'b1;
        end
        else if (!ge1)
        begin
            if (mode > sfsc_pkg::MODE_STOPPING)
            begin
                mode_next = sfsc_pkg::MODE_STOPPING;
                wait_next = '0;
            end
            else if (mode == sfsc_pkg::MODE_STOPPING)
            begin
                if (wait_count >= cfg.run_down_seconds)
                    mode_next = sfsc_pkg::MODE_STOPPED;
            end
            else
            begin
                mode_next = sfsc_pkg::MODE_STOPPED;
            end
        end
        else if (!ge2)
            mode_next = sfsc_pkg::MODE_SPEED1;
        else if (!ge3)
            mode_next = sfsc_pkg::MODE_SPEED2;
        else if (!ge4)
            mode_next = sfsc_pkg::MODE_SPEED3;
        else if (!ge5)
            mode_next = sfsc_pkg::MODE_SPEED4;
        else
            mode_next = sfsc_pkg::MODE_SPEED5;
    end

    assign pins = sfsc_pkg::pin_of(mode_next);

endmodule

>>> design/stepped_fan_speed_controller_core.sv
// stepped fan speed controller
//
// input stream: one request per beat. s_axis_tuser selects the kind
// (0 temperature sample, 1 one-second tick), s_axis_tdata carries the
// temperature in degrees, ignored for ticks.
// output stream: one result per request, m_axis_tdata holds the fan state
// (0 stopped, 1 stopping, 2..6 speed one to five) and the 3-bit pin pattern.
// apb port: six registers at byte offsets 0x00..0x14, thresholds one to five
// and the run-down time in ticks; write them only while the block is idle.
//
// a request sits in the input register, then the compare chain and state
// update fill the result register.
// throughput is one request per cycle while the receiver does not stall.
// reset stops the fan, clears the wait counter, loads default thresholds
// (55/60/65/70/75) and a run-down time of 120, and empties both registers.
// when the receiver stalls the result holds, the input register still takes
// one more request, and s_axis_tready drops until the result is taken.
module stepped_fan_speed_controller_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // apb configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfsc_pkg::ADDR_W-1:0] paddr,
    input  logic [sfsc_pkg::DATA_W-1:0] pwdata,
    output logic [sfsc_pkg::DATA_W-1:0] prdata,
    output logic                         pready,
    // request stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,  // [7:0] temperature
    input  logic                         s_axis_tuser,  // [0] opcode
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [7:0]                   m_axis_tdata   // [2:0] fan_state, [5:3] pin_pattern
);

    sfsc_pkg::sfsc_cfg_t cfg;

    logic                          in_valid_reg, in_valid_next;
    logic                          in_opcode_reg;
    logic [sfsc_pkg::TEMP_W-1:0]  in_temp_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [sfsc_pkg::STATE_W-1:0] out_state_reg;
    logic [sfsc_pkg::PIN_W-1:0]   out_pin_reg;
    logic [sfsc_pkg::STATE_W-1:0] mode_reg, mode_next;
    logic [sfsc_pkg::WAIT_W-1:0]  wait_reg, wait_next;
    logic [sfsc_pkg::PIN_W-1:0]   pins;
    logic                          advance;
    logic                          take;

    sfsc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfsc_step u_step (
        .opcode      (in_opcode_reg),
        .temperature (in_temp_reg),
        .mode        (mode_reg),
        .wait_count  (wait_reg),
        .cfg         (cfg),
        .mode_next   (mode_next),
        .wait_next   (wait_next),
        .pins        (pins)
    );

    // handshake control
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // control and fan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= sfsc_pkg::MODE_STOPPED;
            wait_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                mode_reg <= mode_next;
                wait_reg <= wait_next;
            end
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_opcode_reg <= s_axis_tuser;
            in_temp_reg   <= s_axis_tdata;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_state_reg <= mode_next;
            out_pin_reg   <= pins;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_pin_reg, out_state_reg};

endmodule

>>> design/sfsc_check.sv
module sfsc_check (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // no result ever reports the unused state code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] <= sfsc_pkg::MODE_SPEED5))
        else $error("result carries an invalid fan state");

    // pin pattern always matches the reported state
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:3] == sfsc_pkg::pin_of(m_axis_tdata[2:0])))
        else $error("pin pattern does not match fan state");

    // padding bits stay clear
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:6] == 2'b00))
        else $error("result padding bits not zero");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // configuration port never waits
    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind stepped_fan_speed_controller_core sfsc_check u_sfsc_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 200;
    localparam int PHASES          = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 1500;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 10;
    localparam int LONG_WAIT_TICKS = 8;
    // indexes past the last register, writes there must be dropped
    localparam logic [sfsc_pkg::IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [sfsc_pkg::IDX_W-1:0] REG_SPARE_B = 3'd7;

    typedef struct packed {
        logic [sfsc_pkg::STATE_W-1:0] fan_state;
        logic [sfsc_pkg::PIN_W-1:0]   pins;
    } fan_result_t;

    // fan state predictor and queue of expected results
    class fan_scoreboard;
        logic [sfsc_pkg::TEMP_W-1:0]  thresholds [5];
        logic [sfsc_pkg::WAIT_W-1:0]  run_down;
        logic [sfsc_pkg::STATE_W-1:0] mode;
        logic [sfsc_pkg::WAIT_W-1:0]  wait_count;
        fan_result_t                  expected_q [$];
        int mismatches;
        int results_seen;
        int samples;
        int ticks;
        int stops;

        function new();
            thresholds[0] = sfsc_pkg::RST_THRESHOLD_ONE;
            thresholds[1] = sfsc_pkg::RST_THRESHOLD_TWO;
            thresholds[2] = sfsc_pkg::RST_THRESHOLD_THREE;
            thresholds[3] = sfsc_pkg::RST_THRESHOLD_FOUR;
            thresholds[4] = sfsc_pkg::RST_THRESHOLD_FIVE;
            run_down      = sfsc_pkg::RST_RUN_DOWN;
            mode          = sfsc_pkg::MODE_STOPPED;
            wait_count    = '0;
            mismatches    = 0;
            results_seen  = 0;
            samples       = 0;
            ticks         = 0;
            stops         = 0;
        endfunction

        function void set_reg(logic [sfsc_pkg::IDX_W-1:0] idx,
                              logic [sfsc_pkg::DATA_W-1:0] value);
            case (idx)
                sfsc_pkg::REG_THRESHOLD_ONE:   thresholds[0] = value[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_TWO:   thresholds[1] = value[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_THREE: thresholds[2] = value[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_FOUR:  thresholds[3] = value[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_THRESHOLD_FIVE:  thresholds[4] = value[sfsc_pkg::TEMP_W-1:0];
                sfsc_pkg::REG_RUN_DOWN:        run_down      = value[sfsc_pkg::WAIT_W-1:0];
                default: ;
            endcase
        endfunction

        // drive bits per fan state
        function logic [sfsc_pkg::PIN_W-1:0] pins_for(logic [sfsc_pkg::STATE_W-1:0] state);
            case (state)
                sfsc_pkg::MODE_STOPPING: return 3'd1;
                sfsc_pkg::MODE_SPEED1:   return 3'd1;
                sfsc_pkg::MODE_SPEED2:   return 3'd2;
                sfsc_pkg::MODE_SPEED3:   return 3'd5;
                sfsc_pkg::MODE_SPEED4:   return 3'd3;
                sfsc_pkg::MODE_SPEED5:   return 3'd7;
                default:                 return 3'd0;
            endcase
        endfunction

        function void note_request(logic op, logic [sfsc_pkg::TEMP_W-1:0] temp);
            logic [sfsc_pkg::STATE_W-1:0] next_mode;
            fan_result_t                  exp_res;
            next_mode = mode;
            if (op == sfsc_pkg::OP_TICK)
            begin
                ticks++;
                if (wait_count != sfsc_pkg::WAIT_MAX)
                    wait_count++;
            end
            else
            begin
                samples++;
                // ordered range tests, first match wins
                if (temp < thresholds[0])
                begin
                    if (mode > sfsc_pkg::MODE_STOPPING)
                    begin
                        next_mode  = sfsc_pkg::MODE_STOPPING;
                        wait_count = '0;
                    end
                    else if (mode == sfsc_pkg::MODE_STOPPING)
                    begin
                        if (wait_count >= run_down)
                        begin
                            next_mode = sfsc_pkg::MODE_STOPPED;
                            stops++;
                        end
                    end
                    else
                        next_mode = sfsc_pkg::MODE_STOPPED;
                end
                else if (temp < thresholds[1])
                    next_mode = sfsc_pkg::MODE_SPEED1;
                else if (temp < thresholds[2])
                    next_mode = sfsc_pkg::MODE_SPEED2;
                else if (temp < thresholds[3])
                    next_mode = sfsc_pkg::MODE_SPEED3;
                else if (temp < thresholds[4])
                    next_mode = sfsc_pkg::MODE_SPEED4;
                else
                    next_mode = sfsc_pkg::MODE_SPEED5;
            end
            mode = next_mode;
            exp_res.fan_state = mode;
            exp_res.pins      = pins_for(mode);
            expected_q.push_back(exp_res);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_result(logic [7:0] data);
            fan_result_t                  exp_res;
            logic [sfsc_pkg::STATE_W-1:0] got_state;
            logic [sfsc_pkg::PIN_W-1:0]   got_pins;
            got_state = data[2:0];
            got_pins  = data[5:3];
            results_seen++;
            if (expected_q.size() == 0)
                flag($sformatf("result %0d: none expected, got state %0d pins %0d",
                               results_seen, got_state, got_pins));
            else
            begin
                exp_res = expected_q.pop_front();
                if (got_state !== exp_res.fan_state)
                    flag($sformatf("result %0d: fan_state expected %0d, got %0d",
                                   results_seen, exp_res.fan_state, got_state));
                if (got_pins !== exp_res.pins)
                    flag($sformatf("result %0d: pin_pattern expected %0d, got %0d",
                                   results_seen, exp_res.pins, got_pins));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sfsc_pkg::ADDR_W-1:0]   paddr;
    logic [sfsc_pkg::DATA_W-1:0]   pwdata;
    logic [sfsc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata;   // [7:0] temperature
    logic                          s_axis_tuser;   // [0] opcode
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    logic [7:0]                    m_axis_tdata;   // [2:0] fan_state, [5:3] pin_pattern

    fan_scoreboard sb = new();

    logic hold_long;
    logic tx_gaps;
    logic rx_gaps;
    int   sent;
    int   n_settings;
    int   quiet_cycles;

    stepped_fan_speed_controller_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // note accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    // watchdog on cycles with no transfer of any kind
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stepped_fan_speed_controller_core: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result receiver with random stalls and one long hold-off
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_long = 1'b0;
            end
            stall = rx_gaps ? int'($urandom_range(0, 7)) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    // one request, returns at the edge where it was taken
    task automatic send_request(input logic op, input logic [7:0] temp);
        int gap;
        gap = tx_gaps ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= temp;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic apb_write(input logic [sfsc_pkg::IDX_W-1:0] idx,
                             input logic [sfsc_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // all six registers, upper data bits filled with noise
    task automatic write_settings(input sfsc_pkg::sfsc_cfg_t cfg);
        logic [sfsc_pkg::DATA_W-1:0] noise;
        noise = $urandom;
        apb_write(sfsc_pkg::REG_THRESHOLD_ONE, {noise[31:8], cfg.threshold_one});
        noise = $urandom;
        apb_write(sfsc_pkg::REG_THRESHOLD_TWO, {noise[31:8], cfg.threshold_two});
        noise = $urandom;
        apb_write(sfsc_pkg::REG_THRESHOLD_THREE, {noise[31:8], cfg.threshold_three});
        noise = $urandom;
        apb_write(sfsc_pkg::REG_THRESHOLD_FOUR, {noise[31:8], cfg.threshold_four});
        noise = $urandom;
        apb_write(sfsc_pkg::REG_THRESHOLD_FIVE, {noise[31:8], cfg.threshold_five});
        noise = $urandom;
        apb_write(sfsc_pkg::REG_RUN_DOWN, {noise[31:16], cfg.run_down_seconds});
        n_settings++;
    endtask

    // wait until every expected result has come and the pipeline is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input int p);
        sfsc_pkg::sfsc_cfg_t cfg;
        int                  v;
        case (p)
            1: cfg = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 16'd3};
            2: cfg = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 16'd0};
            3: cfg = '{8'd200, 8'd150, 8'd100, 8'd50, 8'd10, 16'd5};
            4:
            begin
                cfg.threshold_one    = 8'($urandom_range(0, 255));
                cfg.threshold_two    = 8'($urandom_range(0, 255));
                cfg.threshold_three  = 8'($urandom_range(0, 255));
                cfg.threshold_four   = 8'($urandom_range(0, 255));
                cfg.threshold_five   = 8'($urandom_range(0, 255));
                cfg.run_down_seconds = 16'($urandom_range(0, 10));
            end
            5: cfg = '{8'd40, 8'd40, 8'd90, 8'd90, 8'd90, 16'hFFFF};
            7: cfg = '{sfsc_pkg::RST_THRESHOLD_ONE, sfsc_pkg::RST_THRESHOLD_TWO,
                       sfsc_pkg::RST_THRESHOLD_THREE, sfsc_pkg::RST_THRESHOLD_FOUR,
                       sfsc_pkg::RST_THRESHOLD_FIVE, 16'd2};
            default:
            begin
                // ascending thresholds with a short run-down
                v = $urandom_range(10, 90);
                cfg.threshold_one = 8'(v);
                v += $urandom_range(1, 30);
                cfg.threshold_two = 8'(v);
                v += $urandom_range(1, 30);
                cfg.threshold_three = 8'(v);
                v += $urandom_range(1, 30);
                cfg.threshold_four = 8'(v);
                v += $urandom_range(1, 30);
                cfg.threshold_five = 8'(v);
                cfg.run_down_seconds = (p == 0) ? 16'($urandom_range(0, 6)) : 16'd1;
            end
        endcase
        write_settings(cfg);
        // writes past the register file must not land anywhere
        if (p == 4)
        begin
            apb_write(REG_SPARE_A, $urandom);
            apb_write(REG_SPARE_B, $urandom);
        end
    endtask

    // temperatures clustered around the thresholds, at or below the lowest, or uniform over 0..255
    function automatic logic [7:0] pick_temperature();
        int k;
        int t;
        k = $urandom_range(0, 4);
        case ($urandom_range(0, 3))
            0: t = int'(sb.thresholds[k]) + int'($urandom_range(0, 2)) - 1;
            1: t = $urandom_range(0, sb.thresholds[0]);
            default: t = $urandom_range(0, 255);
        endcase
        if (t < 0)
            t = 0;
        if (t > 255)
            t = 255;
        return t[7:0];
    endfunction

    // run, drop below the lowest threshold, tick around the run-down, sample low
    task automatic run_down_sequence();
        int lim;
        int n;
        lim = (sb.run_down > 22) ? 24 : int'(sb.run_down) + 2;
        n = int'($urandom_range(0, lim));
        send_request(sfsc_pkg::OP_SAMPLE, 8'($urandom_range(sb.thresholds[0], 255)));
        send_request(sfsc_pkg::OP_SAMPLE, 8'($urandom_range(0, sb.thresholds[0] - 1)));
        repeat (n) send_request(sfsc_pkg::OP_TICK, 8'($urandom));
        send_request(sfsc_pkg::OP_SAMPLE, 8'($urandom_range(0, sb.thresholds[0] - 1)));
        if ($urandom_range(0, 1))
            send_request(sfsc_pkg::OP_SAMPLE, 8'($urandom_range(0, sb.thresholds[0] - 1)));
    endtask

    // main sequence
    initial
    begin
        int start;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = sfsc_pkg::OP_SAMPLE;
        hold_long     = 1'b0;
        tx_gaps       = 1'b1;
        rx_gaps       = 1'b1;
        sent          = 0;
        n_settings    = 1;
        quiet_cycles  = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk through the default ranges and the run-down entry
        send_request(sfsc_pkg::OP_SAMPLE, 8'd0);
        send_request(sfsc_pkg::OP_TICK, 8'd255);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd255);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd75);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd74);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd70);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd69);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd65);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd64);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd60);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd59);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd55);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd54);
        send_request(sfsc_pkg::OP_TICK, 8'd0);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd0);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd58);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd54);

        // zero run-down: first low sample in stopping stops the fan
        settle();
        apb_write(sfsc_pkg::REG_RUN_DOWN, 32'd0);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd100);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd30);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd30);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd30);

        // longest run-down, low samples keep the fan stopping, back to back
        settle();
        apb_write(sfsc_pkg::REG_RUN_DOWN, 32'h5A5A_FFFF);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        send_request(sfsc_pkg::OP_SAMPLE, 8'd200);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd0);
        repeat (LONG_WAIT_TICKS) send_request(sfsc_pkg::OP_TICK, 8'($urandom));
        send_request(sfsc_pkg::OP_SAMPLE, 8'd0);
        send_request(sfsc_pkg::OP_SAMPLE, 8'd0);

        // random phases under different register settings and idle patterns
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            configure(p);
            tx_gaps = (p % 4 == 0) || (p % 4 == 2);
            rx_gaps = (p % 4 == 0) || (p % 4 == 1);
            if (p == 0)
            begin
                // receiver holds off while requests keep coming
                tx_gaps   = 1'b0;
                hold_long = 1'b1;
            end
            start = sent;
            while (sent - start < ITEMS_PER_PHASE)
            begin
                if (sb.thresholds[0] != 0 && $urandom_range(0, 9) < 3)
                    run_down_sequence();
                else if ($urandom_range(0, 99) < 35)
                    send_request(sfsc_pkg::OP_TICK, 8'($urandom));
                else
                    send_request(sfsc_pkg::OP_SAMPLE, pick_temperature());
            end
        end

        settle();
        $display("ran %0d requests (%0d samples, %0d ticks) under %0d register settings",
                 sent, sb.samples, sb.ticks, n_settings);
        $display("checked %0d results, saw %0d run-down stops, %0d mismatches",
                 sb.results_seen, sb.stops, sb.mismatches);
        if (sb.mismatches == 0)
            $display("stepped_fan_speed_controller_core: match");
        else
            $display("stepped_fan_speed_controller_core: mismatch");
        $finish;
    end

endmodule
